// File: rtl/fixed_range_histogram_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the fixed-range histogram
// Each macro expands to one labeled concurrent assertion on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef FIXED_RANGE_HISTOGRAM_TOP_DEFINES_SVH
`define FIXED_RANGE_HISTOGRAM_TOP_DEFINES_SVH

// Same-cycle implication.
`define FRH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FRH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fhist_pkg.sv
// ---------------------------------------------------------------------------
// fhist_pkg
// Types and constants shared by the histogram front, queue and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fhist_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SEL_W      = 8;
  localparam int BINS_W     = 9;
  localparam int RESULT_W   = 32;
  localparam int CMP_W      = SAMPLE_W + 1;
  localparam int CNT_W      = $clog2(SAMPLE_W);
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [SAMPLE_W-1:0] RESET_RANGE_LOW   = 16'sd0;
  localparam logic signed [SAMPLE_W-1:0] RESET_RANGE_HIGH  = 16'sd100;
  localparam logic [SAMPLE_W-1:0]        RESET_BIN_WIDTH   = 16'd1;
  localparam logic [BINS_W-1:0]          RESET_ACTIVE_BINS = 9'd100;

  typedef enum logic [1:0] {
    CMD_FILL  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_RANGE_LOW   = 2'd0,
    REG_RANGE_HIGH  = 2'd1,
    REG_BIN_WIDTH   = 2'd2,
    REG_ACTIVE_BINS = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic [SEL_W-1:0]           bin_select;
  } cmd_item_t;

  typedef struct packed {
    logic [RESULT_W-1:0] bin_value;
    logic [RESULT_W-1:0] below_total;
    logic [RESULT_W-1:0] above_total;
    logic                status;
  } rsp_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] range_low;
    logic signed [SAMPLE_W-1:0] range_high;
    logic [SAMPLE_W-1:0]        bin_width;
    logic [BINS_W-1:0]          active_bins;
  } cfg_regs_t;

  // Work class decided by the front.
  typedef enum logic [2:0] {
    OP_BIN   = 3'd0,
    OP_BELOW = 3'd1,
    OP_ABOVE = 3'd2,
    OP_READ  = 3'd3,
    OP_CLEAR = 3'd4,
    OP_NOP   = 3'd5
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [SAMPLE_W-1:0] offset;   // sample - range_low, in-range fills only
    logic [SEL_W-1:0]    sel;
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_ADDR,
    BK_READ,
    BK_DONE
  } back_state_t;

endpackage

// File: rtl/fhist_front.sv
// ---------------------------------------------------------------------------
// fhist_front
// Accepts command items, classifies fills against the range, registers the op.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fhist_front import fhist_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd_item,
  input  cfg_regs_t cfg,
  output logic      push_valid,
  input  logic      push_ready,
  output op_t       push_op
);

  logic              full;
  op_t               op;
  op_t               op_next;
  logic [CMP_W-1:0]  diff;

  assign cmd_ready  = !full || push_ready;
  assign push_valid = full;
  assign push_op    = op;

  always_comb begin
    diff = {cmd_item.sample[SAMPLE_W-1], cmd_item.sample}
         - {cfg.range_low[SAMPLE_W-1], cfg.range_low};
    op_next.offset = diff[SAMPLE_W-1:0];
    op_next.sel    = cmd_item.bin_select;
    unique case (cmd_item.cmd)
      CMD_FILL: begin
        priority if (cmd_item.sample < cfg.range_low) begin
          op_next.kind = OP_BELOW;
        end else if (cmd_item.sample > cfg.range_high) begin
          op_next.kind = OP_ABOVE;
        end else begin
          op_next.kind = OP_BIN;
        end
      end
      CMD_READ:  op_next.kind = OP_READ;
      CMD_CLEAR: op_next.kind = OP_CLEAR;
      default:   op_next.kind = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (cmd_ready) begin
      full <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      op <= op_next;
    end
  end

endmodule

// File: rtl/fhist_queue.sv
// ---------------------------------------------------------------------------
// fhist_queue
// Short FIFO of classified ops between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fhist_queue import fhist_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_op
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  op_t           slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [LW-1:0] level;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (level != LW'(QUEUE_DEPTH));
  assign pop_valid  = (level != '0);
  assign pop_op     = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        level <= level + LW'(1);
      end else if (do_pop && !do_push) begin
        level <= level - LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

// File: rtl/fhist_back.sv
// ---------------------------------------------------------------------------
// fhist_back
// Serial bin divide, bin store read-modify-write, counters, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fhist_back import fhist_pkg::*; #(
  parameter int NUM_BINS   = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t cfg,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  op_t       pop_op,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp_item
);

  localparam int AW = $clog2(NUM_BINS);
  localparam logic [CMP_W-1:0] NUM_BINS_C = CMP_W'(NUM_BINS);

  back_state_t         state;
  back_state_t         state_next;
  op_kind_t            kind;
  logic [SAMPLE_W-1:0] quo;
  logic [SAMPLE_W-1:0] rem;
  logic [SAMPLE_W-1:0] quo_next;
  logic [SAMPLE_W-1:0] rem_next;
  logic [SAMPLE_W:0]   rem_sh;
  logic [SAMPLE_W-1:0] divisor;
  logic [CNT_W-1:0]    step;
  logic [AW-1:0]       addr;
  logic                sel_ok;
  logic [CMP_W-1:0]    eff_bins;
  logic [CMP_W-1:0]    active_ext;
  logic [CMP_W-1:0]    clamped;

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [COUNT_BITS-1:0] rd_data;
  logic [NUM_BINS-1:0]   valid_bits;
  logic [COUNT_BITS-1:0] entry;
  logic [COUNT_BITS-1:0] below_count;
  logic [COUNT_BITS-1:0] above_count;
  logic [COUNT_BITS-1:0] below_next;
  logic [COUNT_BITS-1:0] above_next;
  logic [COUNT_BITS-1:0] value;
  logic                  status;
  logic                  commit;
  logic                  mem_we;

  // Effective bin count, zero means one, clipped to the store.
  assign active_ext = CMP_W'(cfg.active_bins);
  always_comb begin
    if (active_ext == '0) begin
      eff_bins = CMP_W'(1);
    end else if (active_ext > NUM_BINS_C) begin
      eff_bins = NUM_BINS_C;
    end else begin
      eff_bins = active_ext;
    end
  end

  assign divisor = (cfg.bin_width == '0) ? SAMPLE_W'(1) : cfg.bin_width;

  // One restoring divide step per cycle.
  always_comb begin
    rem_sh = {rem, quo[SAMPLE_W-1]};
    if (rem_sh >= {1'b0, divisor}) begin
      rem_next = SAMPLE_W'(rem_sh - {1'b0, divisor});
      quo_next = {quo[SAMPLE_W-2:0], 1'b1};
    end else begin
      rem_next = rem_sh[SAMPLE_W-1:0];
      quo_next = {quo[SAMPLE_W-2:0], 1'b0};
    end
  end

  assign clamped = (CMP_W'(quo) >= eff_bins) ? eff_bins - CMP_W'(1) : CMP_W'(quo);

  // Never-written entries read as zero.
  assign entry  = valid_bits[addr] ? rd_data : '0;
  assign commit = (state == BK_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    below_next = below_count;
    above_next = above_count;
    value      = '0;
    status     = 1'b0;
    mem_we     = 1'b0;
    unique case (kind)
      OP_BELOW: below_next = (&below_count) ? below_count
                                            : below_count + COUNT_BITS'(1);
      OP_ABOVE: above_next = (&above_count) ? above_count
                                            : above_count + COUNT_BITS'(1);
      OP_BIN:   mem_we = commit;
      OP_READ: begin
        value  = sel_ok ? entry : '0;
        status = !sel_ok;
      end
      OP_CLEAR: begin
        below_next = '0;
        above_next = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    pop_ready  = (state == BK_IDLE);
    unique case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          unique case (pop_op.kind)
            OP_BIN:  state_next = BK_DIV;
            OP_READ: state_next = BK_READ;
            default: state_next = BK_DONE;
          endcase
        end
      end
      BK_DIV:  if (step == CNT_W'(SAMPLE_W - 1)) state_next = BK_ADDR;
      BK_ADDR: state_next = BK_READ;
      BK_READ: state_next = BK_DONE;
      BK_DONE: if (commit) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      rsp_valid   <= 1'b0;
      valid_bits  <= '0;
      below_count <= '0;
      above_count <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        rsp_valid   <= 1'b1;
        below_count <= below_next;
        above_count <= above_next;
        if (kind == OP_CLEAR) begin
          valid_bits <= '0;
        end else if (mem_we) begin
          valid_bits[addr] <= 1'b1;
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          kind   <= pop_op.kind;
          quo    <= pop_op.offset;
          rem    <= '0;
          step   <= '0;
          addr   <= AW'(pop_op.sel);
          sel_ok <= (CMP_W'(pop_op.sel) < eff_bins);
        end
      end
      BK_DIV: begin
        quo  <= quo_next;
        rem  <= rem_next;
        step <= step + CNT_W'(1);
      end
      BK_ADDR: addr <= AW'(clamped);
      default: ;
    endcase
    if (commit) begin
      rsp_item.bin_value   <= RESULT_W'(value);
      rsp_item.below_total <= RESULT_W'(below_next);
      rsp_item.above_total <= RESULT_W'(above_next);
      rsp_item.status      <= status;
    end
  end

  // Bin store: one port, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= (&entry) ? entry : entry + COUNT_BITS'(1);
    end
    rd_data <= mem[addr];
  end

endmodule

// File: rtl/fixed_range_histogram_top.sv
// Pacing: in-range fills are bounded by the 16-step serial bin divider plus
//   the bin store read and write; the back takes one op at a time.
// Reset: synchronous; registers to reset values, counters and all bin valid
//   flags cleared together by the reset, no clearing pass.
// ---------------------------------------------------------------------------
// fixed_range_histogram_top
// Uniform-bin histogram of signed samples with under/overflow counters.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_range_histogram_top import fhist_pkg::*; #(
  parameter int NUM_BINS   = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // command items
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_item_t   cmd_item,
  // result items
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_item_t   rsp_item,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers, read live by front and back. Writes must arrive
  // only while the block is idle; the block itself does not enforce this.
  cfg_regs_t cfg;

  // Front to queue, queue to back.
  logic push_valid;
  logic push_ready;
  op_t  push_op;
  logic pop_valid;
  logic pop_ready;
  op_t  pop_op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_low   <= RESET_RANGE_LOW;
      cfg.range_high  <= RESET_RANGE_HIGH;
      cfg.bin_width   <= RESET_BIN_WIDTH;
      cfg.active_bins <= RESET_ACTIVE_BINS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RANGE_LOW:   cfg.range_low   <= cfg_data;
        REG_RANGE_HIGH:  cfg.range_high  <= cfg_data;
        REG_BIN_WIDTH:   cfg.bin_width   <= cfg_data;
        REG_ACTIVE_BINS: cfg.active_bins <= cfg_data[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: classify each item as below, above, in-range bin, read, clear
  // or no-op, and compute the offset from range_low for in-range fills.
  fhist_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_item   (cmd_item),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  // Two-entry queue so the front keeps taking items while the divider runs.
  fhist_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  // Back: divide, clamp to last active bin, saturating read-modify-write,
  // counters, and the registered result.
  fhist_back #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp_item   (rsp_item)
  );

`include "fixed_range_histogram_top_defines.svh"

  // A read flagged beyond the active bins never carries a count.
  `FRH_ASSERT_NOW(a_status_zero_value, rsp_valid && rsp_item.status,
                  rsp_item.bin_value == '0, "bad read returned a count")
  // An accepted item is always held by the front on the next cycle.
  `FRH_ASSERT_NEXT(a_front_holds, cmd_valid && cmd_ready, push_valid,
                   "accepted item lost at front")

endmodule

// File: test/fixed_range_histogram_top_tb.sv
// ---------------------------------------------------------------------------
// fixed_range_histogram_top_tb
// Self-checking bench for the uniform-bin histogram. Commands go in over a
// valid/ready channel, and an in-bench copy of the histogram predicts each
// result item. Register settings are swept between phases while the block
// is idle, and sender/receiver idling varies from phase to phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_range_histogram_top_tb;
  import fhist_pkg::*;

  localparam int STORE_BINS  = 256;
  localparam int PHASE_ITEMS = 130;
  localparam int NUM_PHASES  = 12;

  // Histogram state mirror: bins, out-of-range counters and register copy.
  // Every accepted command pushes the result it must produce.
  class histogram_tracker;
    logic [RESULT_W-1:0] bin_count [STORE_BINS];
    logic [RESULT_W-1:0] below_count;
    logic [RESULT_W-1:0] above_count;
    int                  range_low;
    int                  range_high;
    logic [15:0]         bin_width;
    logic [BINS_W-1:0]   active_bins;
    rsp_item_t           awaited_rsp[$];
    int                  errors;

    function new();
      foreach (bin_count[i]) bin_count[i] = '0;
      below_count = '0;
      above_count = '0;
      range_low   = RESET_RANGE_LOW;
      range_high  = RESET_RANGE_HIGH;
      bin_width   = RESET_BIN_WIDTH;
      active_bins = RESET_ACTIVE_BINS;
      errors      = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [15:0] data);
      case (idx)
        REG_RANGE_LOW:   range_low   = $signed(data);
        REG_RANGE_HIGH:  range_high  = $signed(data);
        REG_BIN_WIDTH:   bin_width   = data;
        REG_ACTIVE_BINS: active_bins = data[BINS_W-1:0];
        default: ;
      endcase
    endfunction

    // Zero bins means one, more than the store means the whole store.
    function int bins_in_use();
      if (active_bins == 0) return 1;
      if (active_bins > STORE_BINS) return STORE_BINS;
      return active_bins;
    endfunction

    function logic [RESULT_W-1:0] bump(logic [RESULT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void note_command(cmd_item_t it);
      rsp_item_t   r;
      int          x;
      int unsigned offset;
      int unsigned width;
      int unsigned bin;
      r = '0;
      x = $signed(it.sample);
      case (it.cmd)
        CMD_FILL: begin
          // low above high sends every sample to the below or above counter naturally
          if (x < range_low) begin
            below_count = bump(below_count);
          end else if (x > range_high) begin
            above_count = bump(above_count);
          end else begin
            offset = x - range_low;
            width  = (bin_width == 0) ? 1 : bin_width;
            bin    = offset / width;
            if (bin >= bins_in_use()) bin = bins_in_use() - 1;
            bin_count[bin] = bump(bin_count[bin]);
          end
        end
        CMD_READ: begin
          if (it.bin_select < bins_in_use()) r.bin_value = bin_count[it.bin_select];
          else r.status = 1'b1;
        end
        CMD_CLEAR: begin
          foreach (bin_count[i]) bin_count[i] = '0;
          below_count = '0;
          above_count = '0;
        end
        default: ;
      endcase
      r.below_total = below_count;
      r.above_total = above_count;
      awaited_rsp.push_back(r);
    endfunction

    function void report(string field, logic [RESULT_W-1:0] want, logic [RESULT_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_result(rsp_item_t got);
      rsp_item_t want;
      if (awaited_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = awaited_rsp.pop_front();
      if (got.bin_value !== want.bin_value)
        report("bin_value", want.bin_value, got.bin_value);
      if (got.below_total !== want.below_total)
        report("below_total", want.below_total, got.below_total);
      if (got.above_total !== want.above_total)
        report("above_total", want.above_total, got.above_total);
      if (got.status !== want.status)
        report("status", RESULT_W'(want.status), RESULT_W'(got.status));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_ready;
  cmd_item_t   cmd_item;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_item_t   rsp_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  histogram_tracker hist;

  // per-phase idling, in percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Fixed settings swept first; later phases pick random ones.
  // Word 'hFE00 for active bins masks to zero bins (one bin in use).
  // Width 0 is taken as one; 511 bins is clipped to the store.
  int fixed_lo   [8] = '{0, -32768, -1000, 50, -200, 10, -32768, 32000};
  int fixed_hi   [8] = '{100, 32767, 1000, -50, 300, 20, -32000, 32767};
  int fixed_w    [8] = '{1, 65535, 8, 3, 0, 1, 4, 100};
  int fixed_bins [8] = '{100, 256, 256, 20, 511, 'hFE00, 200, 9};

  fixed_range_histogram_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("fixed_range_histogram_top verification failed");
    $finish;
  end

  // Result side: sample at the edge, then pick readiness for the next cycle.
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) hist.check_result(rsp_item);
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic cmd_item_t make_cmd(cmd_t c, int s, int sel);
    cmd_item_t it;
    it.cmd        = c;
    it.sample     = s[SAMPLE_W-1:0];
    it.bin_select = sel[SEL_W-1:0];
    return it;
  endfunction

  // Mostly fills near the range and reads of live bins; some noise on top.
  function automatic cmd_item_t random_cmd();
    cmd_item_t it;
    int        r;
    int        lo;
    int        hi;
    lo = hist.range_low;
    hi = hist.range_high;
    it.sample     = SAMPLE_W'($urandom);
    it.bin_select = SEL_W'($urandom_range(0, 255));
    r = $urandom_range(99);
    if (r < 58) begin
      it.cmd = CMD_FILL;
      r = $urandom_range(99);
      if (r < 15) begin
        // keep the fully random sample
      end else if (r < 30) begin
        case ($urandom_range(3))
          0: it.sample = SAMPLE_W'(lo);
          1: it.sample = SAMPLE_W'(hi);
          2: it.sample = SAMPLE_W'(lo - 1);
          default: it.sample = SAMPLE_W'(hi + 1);
        endcase
      end else if (lo <= hi) begin
        it.sample = SAMPLE_W'(lo + $urandom_range(0, hi - lo));
      end
    end else if (r < 92) begin
      it.cmd = CMD_READ;
      if ($urandom_range(99) < 75) begin
        it.bin_select = SEL_W'($urandom_range(0, hist.bins_in_use() - 1));
      end
    end else if (r < 96) begin
      it.cmd = CMD_CLEAR;
    end else begin
      it.cmd = CMD_NOP;
    end
    return it;
  endfunction

  // Valid stays high across back-to-back items; it only drops for an idle gap.
  task automatic send_cmd(cmd_item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_valid <= 1'b1;
    cmd_item  <= it;
    do @(posedge clk); while (!cmd_ready);
    hist.note_command(it);
  endtask

  // Drop valid and wait until every awaited result is back.
  task automatic drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (hist.awaited_rsp.size() != 0);
  endtask

  task automatic write_config(int lo, int hi, int w, int bins_word);
    logic [15:0] vals [4];
    vals = '{lo[15:0], hi[15:0], w[15:0], bins_word[15:0]};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      hist.set_register(cfg_reg_t'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int lo;
    int hi;
    int w;
    int nb;
    hist      = new();
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd_item  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_RANGE_LOW;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, on reset settings [0,100], width 1, 100 bins.
    send_cmd(make_cmd(CMD_FILL, 0, 0));
    send_cmd(make_cmd(CMD_FILL, 100, 0));       // range top, clamps into bin 99
    send_cmd(make_cmd(CMD_FILL, 99, 0));
    send_cmd(make_cmd(CMD_FILL, 50, 0));
    send_cmd(make_cmd(CMD_FILL, -1, 0));        // just below
    send_cmd(make_cmd(CMD_FILL, 101, 0));       // just above
    send_cmd(make_cmd(CMD_FILL, -32768, 0));
    send_cmd(make_cmd(CMD_FILL, 32767, 255));
    send_cmd(make_cmd(CMD_READ, 0, 0));
    send_cmd(make_cmd(CMD_READ, 0, 99));
    send_cmd(make_cmd(CMD_READ, -1, 50));
    send_cmd(make_cmd(CMD_READ, 0, 100));       // first bin past active ones
    send_cmd(make_cmd(CMD_READ, 0, 255));
    send_cmd(make_cmd(CMD_NOP, -1, 255));
    send_cmd(make_cmd(CMD_CLEAR, 0, 0));
    send_cmd(make_cmd(CMD_READ, 0, 99));
    send_cmd(make_cmd(CMD_FILL, 100, 0));
    send_cmd(make_cmd(CMD_READ, 0, 99));

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p < 8) begin
        lo = fixed_lo[p];
        hi = fixed_hi[p];
        w  = fixed_w[p];
        nb = fixed_bins[p];
      end else begin
        lo = $urandom_range(0, 65535);
        lo = lo - 32768;
        hi = lo + $urandom_range(0, 3000);
        if (hi > 32767) hi = 32767;
        if ($urandom_range(3) == 0) begin
          // inverted range: nothing lands in a bin
          hi = lo - $urandom_range(1, 500);
          if (hi < -32768) hi = -32768;
        end
        w  = $urandom_range(1, 40);
        nb = $urandom_range(1, 256);
      end
      write_config(lo, hi, w, nb);

      // idle pattern cycles through: none, sender, receiver, both
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) send_cmd(random_cmd());
    end

    drain();
    // a stray extra result would surface within the longest latency
    repeat (40) @(posedge clk);
    if (hist.errors == 0 && hist.awaited_rsp.size() == 0) begin
      $display("fixed_range_histogram_top verification clean");
    end else begin
      $display("fixed_range_histogram_top verification failed");
    end
    $finish;
  end

endmodule
